/* rtl/sefr_pkg.sv */
package sefr_pkg;

    // Frame store geometry
    localparam int FRAME_DEPTH = 64;
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);

    // Frame layout: head byte, two length bytes, payload, tail byte
    localparam int HEADER_BYTES      = 3;
    localparam int FRAME_OVERHEAD    = 4;
    localparam int MIN_HELD_FOR_TAIL = 3;

    localparam logic [7:0] HEAD_RESET = 8'h02;
    localparam logic [7:0] TAIL_RESET = 8'h03;

    // Input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_HEAD = 1'b0;
    localparam logic CFG_TAIL = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFRAME  = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ADDR_W-1:0] t_addr;

    // Controller to datapath
    typedef struct packed {
        logic store_byte;   // a received byte is accepted
        logic take;         // a take is accepted
        logic rd_first;     // fetch the first payload byte
        logic rd_next;      // fetch the following payload byte
        logic show_status;  // the output shows the status result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic follows;      // ok status with a non-empty payload
        logic last_byte;    // the byte on show is the final payload byte
    } t_sts;

endpackage

/* rtl/sefr_ctrl.sv */
module sefr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    input  logic           i_out_stall,
    input  sefr_pkg::t_sts i_sts,
    output sefr_pkg::t_cmd o_cmd,
    output logic           o_in_stall,
    output logic           o_out_valid
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_STATUS = 3'b010,
        S_SEND   = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_out_take;

    assign w_out_take = o_out_valid && !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.store_byte = i_in_valid && (i_opcode == sefr_pkg::OP_BYTE);
                o_cmd.take       = i_in_valid && (i_opcode == sefr_pkg::OP_TAKE);
                if (o_cmd.take) begin
                    n_state = S_STATUS;
                end
            end
            S_STATUS: begin
                o_cmd.show_status = 1'b1;
                if (w_out_take) begin
                    if (i_sts.follows) begin
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_SEND;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SEND: begin
                if (w_out_take) begin
                    if (i_sts.last_byte) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_STATUS) || (r_state == S_SEND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/sefr_dp.sv */
module sefr_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sefr_pkg::t_cmd i_cmd,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [7:0]     i_cfg_data,
    output sefr_pkg::t_sts o_sts,
    output logic           o_is_status,
    output logic [1:0]     o_status_code,
    output logic [5:0]     o_payload_length,
    output logic [7:0]     o_payload_byte,
    output logic           o_last
);

    logic [7:0] r_mem [sefr_pkg::FRAME_DEPTH];

    logic [7:0]      r_head;
    logic [7:0]      r_tail;
    sefr_pkg::t_cnt  r_count;
    logic            r_in_frame;
    logic            r_done;
    logic [7:0]      r_len_hi;
    logic [7:0]      r_len_lo;
    logic [1:0]      r_code;
    logic [5:0]      r_plen;
    sefr_pkg::t_cnt  r_send_len;
    sefr_pkg::t_addr r_idx;
    logic [7:0]      r_rd_data;

    logic            w_we;
    sefr_pkg::t_addr w_wa;
    logic [15:0]     w_declared;
    logic            w_match;
    sefr_pkg::t_addr n_idx;
    sefr_pkg::t_addr w_ra;
    logic            w_re;
    sefr_pkg::t_cnt  w_send_m1;

    assign w_declared = {r_len_hi, r_len_lo};
    assign w_match    = (r_count >= sefr_pkg::t_cnt'(sefr_pkg::FRAME_OVERHEAD))
                     && (w_declared == (16'(r_count) - 16'(sefr_pkg::FRAME_OVERHEAD)));

    // Store path: write position follows the fill count
    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        if (i_cmd.store_byte && !r_done) begin
            if (!r_in_frame) begin
                w_we = (i_rx_byte == r_head);
            end else if (r_count < sefr_pkg::t_cnt'(sefr_pkg::FRAME_DEPTH)) begin
                w_we = 1'b1;
                w_wa = r_count[sefr_pkg::ADDR_W-1:0];
            end
        end
    end

    // Read path: first payload byte sits right after the header
    assign n_idx = i_cmd.rd_first ? '0 : r_idx + 1'b1;
    assign w_ra  = sefr_pkg::t_addr'(sefr_pkg::HEADER_BYTES) + n_idx;
    assign w_re  = i_cmd.rd_first || i_cmd.rd_next;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= i_rx_byte;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && (w_wa == sefr_pkg::t_addr'(1))) begin
            r_len_hi <= i_rx_byte;
        end
        if (w_we && (w_wa == sefr_pkg::t_addr'(2))) begin
            r_len_lo <= i_rx_byte;
        end
        if (w_re) begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= sefr_pkg::HEAD_RESET;
            r_tail     <= sefr_pkg::TAIL_RESET;
            r_count    <= '0;
            r_in_frame <= 1'b0;
            r_done     <= 1'b0;
            r_code     <= sefr_pkg::ST_OK;
            r_plen     <= '0;
            r_send_len <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sefr_pkg::CFG_HEAD: r_head <= i_cfg_data;
                    sefr_pkg::CFG_TAIL: r_tail <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.store_byte && !r_done) begin
                if (!r_in_frame) begin
                    if (i_rx_byte == r_head) begin
                        r_count    <= sefr_pkg::t_cnt'(1);
                        r_in_frame <= 1'b1;
                    end
                end else if (r_count >= sefr_pkg::t_cnt'(sefr_pkg::FRAME_DEPTH)) begin
                    r_count    <= '0;
                    r_in_frame <= 1'b0;
                end else begin
                    if ((i_rx_byte == r_tail)
                        && (r_count > sefr_pkg::t_cnt'(sefr_pkg::MIN_HELD_FOR_TAIL))) begin
                        r_done <= 1'b1;
                    end
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.take) begin
                r_plen     <= '0;
                r_send_len <= '0;
                if (!r_done) begin
                    r_code <= sefr_pkg::ST_NOFRAME;
                end else begin
                    r_count    <= '0;
                    r_in_frame <= 1'b0;
                    r_done     <= 1'b0;
                    if (w_match) begin
                        r_code     <= sefr_pkg::ST_OK;
                        r_plen     <= w_declared[5:0];
                        r_send_len <= w_declared[sefr_pkg::CNT_W-1:0];
                    end else begin
                        r_code <= sefr_pkg::ST_MISMATCH;
                    end
                end
            end
        end
    end

    assign w_send_m1       = r_send_len - sefr_pkg::t_cnt'(1);
    assign o_sts.follows   = (r_code == sefr_pkg::ST_OK) && (r_send_len != '0);
    assign o_sts.last_byte = (r_idx == w_send_m1[sefr_pkg::ADDR_W-1:0]);

    assign o_is_status      = i_cmd.show_status;
    assign o_status_code    = i_cmd.show_status ? r_code : sefr_pkg::ST_OK;
    assign o_payload_length = i_cmd.show_status ? r_plen : 6'd0;
    assign o_payload_byte   = i_cmd.show_status ? 8'd0 : r_rd_data;
    assign o_last           = i_cmd.show_status ? !o_sts.follows : o_sts.last_byte;

endmodule

/* rtl/stx_etx_frame_receiver.sv */
// Framed serial receiver. Bytes (opcode 0) are gathered into a 64-entry
// frame store: while hunting only the head byte is kept and opens a frame,
// inside a frame every byte is stored, and the tail byte closes the frame
// once more than three bytes are held. A byte arriving with the store full
// drops the partial frame and restarts hunting; bytes arriving while a
// closed frame waits are ignored. A take (opcode 1) answers with one status
// transfer (ok, no completed frame, or length mismatch against the
// big-endian length in bytes 1 and 2) and, when ok, the payload bytes in
// frame order, the final transfer of each take carrying o_last. A take
// occupies the block through its status transfer and each payload
// transfer; payload bytes stream one per cycle while the sink does not
// stall, because the next store read is issued in the same cycle the
// current byte is transferred, so the single registered read port of the
// frame store sets that rate. The input is stalled from the accepted take
// until its last result is transferred. Head and tail byte values are
// written through the configuration port (index 0 head, index 1 tail);
// o_cfg_ready is always high.
module stx_etx_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_is_status,
    output logic [1:0] o_status_code,
    output logic [5:0] o_payload_length,
    output logic [7:0] o_payload_byte,
    output logic       o_last,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    sefr_pkg::t_cmd w_cmd;
    sefr_pkg::t_sts w_sts;

    // Configuration writes never wait
    assign o_cfg_ready = 1'b1;

    // Sequence take, status and payload transfers
    sefr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Hold the frame store, fill count, flags and result fields
    sefr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_sts            (w_sts),
        .o_is_status      (o_is_status),
        .o_status_code    (o_status_code),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

endmodule

/* rtl/sefr_chk.sv */
module sefr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_opcode,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_is_status,
    input logic [1:0] o_status_code,
    input logic [5:0] o_payload_length,
    input logic [7:0] o_payload_byte,
    input logic       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_is_status) && $stable(o_status_code)
            && $stable(o_payload_byte) && $stable(o_last)))
        else $error("stalled result changed");

    a_take_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_opcode == sefr_pkg::OP_TAKE))
            |=> (o_out_valid && o_is_status))
        else $error("take not answered by a status result");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_status)
            |-> (o_status_code == sefr_pkg::ST_OK && o_payload_length == 6'd0))
        else $error("payload result carries status fields");

endmodule

bind stx_etx_frame_receiver sefr_chk u_sefr_chk (.*);

/* tb/tb_stx_etx_frame_receiver.sv */
`timescale 1ns / 100ps

// Self-checking bench for the framed serial receiver. Bytes and take commands
// go in on the input channel; a shadow of the frame store works out the
// status and payload transfers that each take must produce. Both channels idle
// and stall at random; the head and tail byte values are rewritten between
// phases while the block is quiet.
module tb_stx_etx_frame_receiver;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_WAIT      = 16;
    localparam int RANDOM_ITEMS  = 40;
    localparam int MAX_PAYLOAD   = sefr_pkg::FRAME_DEPTH - sefr_pkg::FRAME_OVERHEAD;

    // One result transfer as it appears on the output ports
    typedef struct packed {
        logic       is_status;
        logic [1:0] code;
        logic [5:0] plen;
        logic [7:0] pbyte;
        logic       last;
    } t_reply;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_opcode    = sefr_pkg::OP_BYTE;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = sefr_pkg::CFG_HEAD;
    logic [7:0] i_cfg_data  = 8'h00;

    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_is_status;
    logic [1:0] o_status_code;
    logic [5:0] o_payload_length;
    logic [7:0] o_payload_byte;
    logic       o_last;
    logic       o_cfg_ready;

    stx_etx_frame_receiver uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_status      (o_is_status),
        .o_status_code    (o_status_code),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the receiver state
    logic [7:0] shadow_store [sefr_pkg::FRAME_DEPTH];
    int         held_bytes  = 0;
    bit         framing     = 1'b0;
    bit         frame_ready = 1'b0;
    logic [7:0] head_val    = sefr_pkg::HEAD_RESET;
    logic [7:0] tail_val    = sefr_pkg::TAIL_RESET;

    t_reply pending_replies [$];
    int     work_items   = 0;   // bytes and takes that the block acts on
    int     mismatches   = 0;
    int     cycles       = 0;
    int     in_wait_max  = MAX_WAIT;
    int     out_wait_max = MAX_WAIT;

    // Give up if the run hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** stx_etx_frame_receiver: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------

    // Zero now and then even when idling is on, so back-to-back runs occur
    function automatic int draw_wait(input int limit);
        if (limit == 0 || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, limit);
    endfunction

    function automatic logic [7:0] pick_other(input logic [7:0] avoid);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == avoid);
        return b;
    endfunction

    // ---------------------------------------------------------------
    // Shadow of the frame logic
    // ---------------------------------------------------------------

    function automatic void push_status(input logic [1:0] code, input logic [5:0] plen,
                                        input logic last);
        t_reply r;
        r.is_status = 1'b1;
        r.code      = code;
        r.plen      = plen;
        r.pbyte     = 8'h00;
        r.last      = last;
        pending_replies.push_back(r);
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        // A closed frame blocks everything until it is taken
        if (frame_ready)
            return;
        // Hunting: only the head byte opens a frame, all else is dropped
        if (!framing) begin
            if (b == head_val) begin
                shadow_store[0] = b;
                held_bytes      = 1;
                framing         = 1'b1;
                work_items++;
            end
            return;
        end
        work_items++;
        // Store full: drop the byte and the partial frame, restart hunting
        if (held_bytes >= sefr_pkg::FRAME_DEPTH) begin
            held_bytes = 0;
            framing    = 1'b0;
            return;
        end
        shadow_store[held_bytes] = b;
        // Tail closes only once the head, both length bytes and a payload byte are behind it
        if (b == tail_val && held_bytes > sefr_pkg::MIN_HELD_FOR_TAIL)
            frame_ready = 1'b1;
        held_bytes++;
    endfunction

    function automatic void take_frame();
        int          len;
        logic [15:0] declared;
        t_reply      r;
        work_items++;
        if (!frame_ready) begin
            push_status(sefr_pkg::ST_NOFRAME, '0, 1'b1);
            return;
        end
        len         = held_bytes;
        held_bytes  = 0;
        framing     = 1'b0;
        frame_ready = 1'b0;
        if (len < sefr_pkg::FRAME_OVERHEAD || len > sefr_pkg::FRAME_DEPTH) begin
            push_status(sefr_pkg::ST_MISMATCH, '0, 1'b1);
            return;
        end
        // Declared length is big-endian in bytes 1 and 2
        declared = {shadow_store[1], shadow_store[2]};
        if (declared != 16'(len - sefr_pkg::FRAME_OVERHEAD)) begin
            push_status(sefr_pkg::ST_MISMATCH, '0, 1'b1);
            return;
        end
        push_status(sefr_pkg::ST_OK, declared[5:0], declared == 16'd0);
        for (int i = 0; i < int'(declared); i++) begin
            r.is_status = 1'b0;
            r.code      = '0;
            r.plen      = '0;
            r.pbyte     = shadow_store[sefr_pkg::HEADER_BYTES + i];
            r.last      = (i + 1 == int'(declared));
            pending_replies.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result side: random stalls and the check of every transfer
    // ---------------------------------------------------------------

    task automatic check_reply();
        t_reply got;
        t_reply want;
        got.is_status = o_is_status;
        got.code      = o_status_code;
        got.plen      = o_payload_length;
        got.pbyte     = o_payload_byte;
        got.last      = o_last;
        if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0d] unexpected transfer: %s=%0b code=%0d len=%0d byte=%02h last=%0b",
                         cycles, "status", got.is_status, got.code, got.plen, got.pbyte,
                         got.last);
            return;
        end
        want = pending_replies.pop_front();
        if (got.is_status !== want.is_status || got.code !== want.code ||
            got.plen !== want.plen || got.pbyte !== want.pbyte || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0d] mismatch: expected status=%0b code=%0d len=%0d byte=%02h last=%0b",
                         cycles, want.is_status, want.code, want.plen, want.pbyte, want.last);
                $display("[%0d]           actual   status=%0b code=%0d len=%0d byte=%02h last=%0b",
                         cycles, got.is_status, got.code, got.plen, got.pbyte, got.last);
            end
        end
    endtask

    // Hold stall for a drawn number of cycles after each transfer; start a hold
    // now and then while nothing is expected, so first transfers meet stalls too
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                check_reply();
                hold = draw_wait(out_wait_max);
            end else if (hold == 0 && pending_replies.size() == 0 &&
                         $urandom_range(0, 7) == 0) begin
                hold = draw_wait(out_wait_max);
            end
            i_out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Enter and leave at a rising edge. Valid stays high into the next item
    // when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = draw_wait(in_wait_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == sefr_pkg::OP_BYTE)
            absorb_byte(b);
        else
            take_frame();
    endtask

    // The data byte of a take is ignored by the block; drive it at random
    task automatic send_take();
        send_item(sefr_pkg::OP_TAKE, 8'($urandom_range(0, 255)));
    endtask

    // Send a head byte, the length, plen payload bytes and the tail byte
    task automatic send_frame(input int plen, input bit bad_len, input bit allow_tail);
        logic [15:0] declared;
        logic [7:0]  b;
        declared = 16'(plen);
        if (bad_len)
            do declared = 16'($urandom_range(0, 65535)); while (declared == 16'(plen));
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_item(sefr_pkg::OP_BYTE, declared[15:8]);
        send_item(sefr_pkg::OP_BYTE, declared[7:0]);
        for (int k = 0; k < plen; k++) begin
            b = allow_tail ? 8'($urandom_range(0, 255)) : pick_other(tail_val);
            send_item(sefr_pkg::OP_BYTE, b);
        end
        send_item(sefr_pkg::OP_BYTE, tail_val);
    endtask

    // Drop valid and wait until every expected transfer is in
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only call when settled
    task automatic write_reg(input logic idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == sefr_pkg::CFG_HEAD)
            head_val = val;
        else
            tail_val = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Stray bytes while hunting are dropped; a take then finds nothing
    task automatic test_hunting();
        send_item(sefr_pkg::OP_BYTE, 8'h00);
        send_item(sefr_pkg::OP_BYTE, 8'hFF);
        send_item(sefr_pkg::OP_BYTE, 8'h5A);
        send_item(sefr_pkg::OP_TAKE, 8'hFF);
    endtask

    task automatic test_short_frames();
        // smallest frame that can close: one payload byte
        send_frame(1, 1'b0, 1'b0);
        send_take();
        // tail in the payload slot is still data; the next tail closes
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_item(sefr_pkg::OP_BYTE, 8'h00);
        send_item(sefr_pkg::OP_BYTE, 8'h01);
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_take();
        // a declared length of zero never matches a frame that closed
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_item(sefr_pkg::OP_BYTE, 8'h00);
        send_item(sefr_pkg::OP_BYTE, 8'h00);
        send_item(sefr_pkg::OP_BYTE, 8'h77);
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_take();
        // bytes after the close are ignored, a head byte included
        send_frame(2, 1'b0, 1'b0);
        send_item(sefr_pkg::OP_BYTE, 8'hFF);
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_take();
    endtask

    // A take on a partial frame reports nothing and leaves it filling
    task automatic test_partial_take();
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_item(sefr_pkg::OP_BYTE, 8'h00);
        send_item(sefr_pkg::OP_BYTE, 8'h02);
        send_take();
        send_item(sefr_pkg::OP_BYTE, 8'hAB);
        send_item(sefr_pkg::OP_BYTE, 8'hCD);
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_take();
    endtask

    task automatic test_length_mismatch();
        // all-ones declared length
        send_item(sefr_pkg::OP_BYTE, head_val);
        send_item(sefr_pkg::OP_BYTE, 8'hFF);
        send_item(sefr_pkg::OP_BYTE, 8'hFF);
        send_item(sefr_pkg::OP_BYTE, 8'h11);
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_take();
        send_frame(4, 1'b1, 1'b0);
        send_take();
    endtask

    // Frame that fills the store exactly: longest payload
    task automatic test_full_frame();
        send_frame(MAX_PAYLOAD, 1'b0, 1'b0);
        send_take();
    endtask

    // Fill the store without a tail; the next byte drops the frame
    task automatic test_overflow();
        send_item(sefr_pkg::OP_BYTE, head_val);
        repeat (sefr_pkg::FRAME_DEPTH - 1) send_item(sefr_pkg::OP_BYTE, pick_other(tail_val));
        send_item(sefr_pkg::OP_BYTE, tail_val);
        send_take();
        // hunting again: a fresh frame goes through
        send_frame(3, 1'b0, 1'b0);
        send_take();
    endtask

    // Extreme head and tail values, and head equal to tail
    task automatic test_register_extremes();
        settle();
        write_reg(sefr_pkg::CFG_HEAD, 8'h00);
        write_reg(sefr_pkg::CFG_TAIL, 8'hFF);
        send_item(sefr_pkg::OP_BYTE, 8'h01);
        send_frame(3, 1'b0, 1'b0);
        send_take();
        settle();
        write_reg(sefr_pkg::CFG_HEAD, 8'hFF);
        write_reg(sefr_pkg::CFG_TAIL, 8'h00);
        send_frame(5, 1'b0, 1'b0);
        send_take();
        settle();
        write_reg(sefr_pkg::CFG_HEAD, 8'hA5);
        write_reg(sefr_pkg::CFG_TAIL, 8'hA5);
        send_frame(2, 1'b0, 1'b0);
        send_take();
    endtask

    // Mostly well-formed frames with random content, plus noise and broken
    // sequences, over four register settings and idling mixes
    task automatic test_random_traffic();
        int target;
        int r;
        int plen;
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            if (phase > 0) begin
                write_reg(sefr_pkg::CFG_HEAD, 8'($urandom_range(0, 255)));
                write_reg(sefr_pkg::CFG_TAIL, 8'($urandom_range(0, 255)));
            end
            case (phase)
                0: begin in_wait_max = MAX_WAIT; out_wait_max = MAX_WAIT; end
                1: begin in_wait_max = 0;        out_wait_max = 0;        end
                2: begin in_wait_max = MAX_WAIT; out_wait_max = 0;        end
                default: begin in_wait_max = 0;  out_wait_max = MAX_WAIT; end
            endcase
            target = work_items + RANDOM_ITEMS / 4;
            while (work_items < target) begin
                r    = $urandom_range(0, 19);
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_PAYLOAD)
                                                   : $urandom_range(1, 12);
                if (r < 14) begin
                    send_frame(plen, $urandom_range(0, 5) == 0, $urandom_range(0, 7) == 0);
                    send_take();
                end else if (r < 16) begin
                    // noise: loose bytes and takes
                    repeat ($urandom_range(1, 4))
                        send_item(($urandom_range(0, 3) == 0) ? sefr_pkg::OP_TAKE
                                                              : sefr_pkg::OP_BYTE,
                                  8'($urandom_range(0, 255)));
                end else if (r < 18) begin
                    // broken: a frame cut short, then a take
                    send_item(sefr_pkg::OP_BYTE, head_val);
                    repeat ($urandom_range(0, 3))
                        send_item(sefr_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
                    send_take();
                end else begin
                    // second frame arrives before the first is taken
                    send_frame($urandom_range(1, 6), 1'b0, 1'b0);
                    send_frame($urandom_range(1, 6), 1'b0, 1'b0);
                    send_take();
                end
            end
        end
        in_wait_max  = MAX_WAIT;
        out_wait_max = MAX_WAIT;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_hunting();
        test_short_frames();
        test_partial_take();
        test_length_mismatch();
        test_full_frame();
        test_overflow();
        test_register_extremes();
        test_random_traffic();

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("** stx_etx_frame_receiver: PASSED **");
        end else begin
            $display("** stx_etx_frame_receiver: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/sefr_pkg.sv
rtl/sefr_ctrl.sv
rtl/sefr_dp.sv
rtl/stx_etx_frame_receiver.sv
rtl/sefr_chk.sv
tb/tb_stx_etx_frame_receiver.sv
